@@ src/fpps_pkg.sv @@
// Shared types and constants of the flash page program sequencer.
// Used by fpps_chunk and flash_page_program_sequencer; depends on nothing.
package fpps_pkg;

  localparam int PAGE_BYTES_DEF   = 256;
  localparam int ADDRESS_BITS_DEF = 24;

  localparam int PAGE_W   = 16;
  localparam int OFFSET_W = 8;
  localparam int LEN_W    = 25;
  localparam int STATUS_W = 8;
  localparam int ADDR_W   = 24;
  localparam int BYTES_W  = 9;
  localparam int ACTION_W = 3;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_BUSY = 8'h01;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_XFER = 2'd1,
    PH_PROG = 2'd2
  } phase_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE   = 3'd0,
    ACT_CHUNK  = 3'd1,
    ACT_END    = 3'd2,
    ACT_DONE   = 3'd3,
    ACT_REJECT = 3'd4
  } action_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [BYTES_W-1:0] bytes;
  } chunk_t;

endpackage

@@ src/flash_page_program_sequencer.sv @@
// Top level of the flash page program sequencer: input register, phase control,
// result register. Depends on fpps_pkg and fpps_chunk.
//
//  channel | direction | tuser  | tdata
//  in_     | request   | cmd    | first_page, start_offset, total_length, dma_done, flash_status
//  out_    | result    | action | chunk_address, chunk_bytes, data_position, is_idle
//
// One request per cycle unless out_tready holds the result register; a request is
// taken into the input register, and its result is offered from the result register.
// Each step is one compare-and-update on the sequence registers plus the chunk
// subtract and compare in fpps_chunk.
// Reset is synchronous, active low, and returns the sequencer to idle with empty stages.
// When out_tready is low the input register still takes one more request.
module flash_page_program_sequencer #(
  parameter int PAGE_BYTES   = fpps_pkg::PAGE_BYTES_DEF,
  parameter int ADDRESS_BITS = fpps_pkg::ADDRESS_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [15:0] first_page, [23:16] start_offset, [48:24] total_length,
  // [49] dma_done, [57:50] flash_status, [63:58] zero
  input  logic [fpps_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] cmd
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [23:0] chunk_address, [32:24] chunk_bytes, [57:33] data_position,
  // [58] is_idle, [63:59] zero
  output logic [fpps_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [2:0] action
  output logic [fpps_pkg::ACTION_W-1:0]        out_tuser
);

  localparam int PAGE_BITS = $clog2(PAGE_BYTES);
  localparam logic [fpps_pkg::OFFSET_W-1:0] OFF_MASK =
    (PAGE_BITS >= fpps_pkg::OFFSET_W) ? {fpps_pkg::OFFSET_W{1'b1}}
                                      : fpps_pkg::OFFSET_W'((1 << PAGE_BITS) - 1);

  // input register
  logic                              s1_v_r;
  logic                              s1_cmd_r;
  logic [fpps_pkg::PAGE_W-1:0]       s1_page_r;
  logic [fpps_pkg::OFFSET_W-1:0]     s1_off_r;
  logic [fpps_pkg::LEN_W-1:0]        s1_len_r;
  logic                              s1_dma_r;
  logic [fpps_pkg::STATUS_W-1:0]     s1_stat_r;

  // sequence state
  fpps_pkg::phase_t                  phase_r, phase_nxt;
  logic [fpps_pkg::PAGE_W-1:0]       page_r, page_nxt;
  logic [fpps_pkg::OFFSET_W-1:0]     offset_r, offset_nxt;
  logic [fpps_pkg::LEN_W-1:0]        len_r, len_nxt;
  logic [fpps_pkg::LEN_W-1:0]        done_r, done_nxt;
  logic [fpps_pkg::BYTES_W-1:0]      count_r, count_nxt;

  // result register
  logic                              out_v_r;
  fpps_pkg::action_t                 out_action_r, action_nxt;
  logic [fpps_pkg::ADDR_W-1:0]       out_addr_r, addr_nxt;
  logic [fpps_pkg::BYTES_W-1:0]      out_bytes_r, bytes_nxt;
  logic [fpps_pkg::LEN_W-1:0]        out_pos_r, pos_nxt;
  logic                              out_idle_r;

  logic                              s1_adv;
  logic                              step;
  logic                              is_start;
  logic                              busy;
  logic [fpps_pkg::LEN_W-1:0]        done_sum;
  logic                              all_done;
  logic [fpps_pkg::PAGE_W-1:0]       calc_page;
  logic [fpps_pkg::OFFSET_W-1:0]     calc_off;
  logic [fpps_pkg::LEN_W-1:0]        calc_len;
  logic [fpps_pkg::LEN_W-1:0]        calc_done;
  fpps_pkg::chunk_t                  chunk;

  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign step      = s1_v_r && s1_adv;

  assign is_start = (s1_cmd_r == fpps_pkg::CMD_START);
  assign busy     = |(s1_stat_r & fpps_pkg::STATUS_BUSY);
  assign done_sum = done_r + fpps_pkg::LEN_W'(count_r);
  assign all_done = (done_sum >= len_r);

  // pick operands for the chunk: a fresh start or the next page
  always_comb begin
    if (is_start) begin
      calc_page = s1_page_r;
      calc_off  = s1_off_r & OFF_MASK;
      calc_len  = s1_len_r;
      calc_done = '0;
    end else begin
      calc_page = page_r + fpps_pkg::PAGE_W'(1);
      calc_off  = '0;
      calc_len  = len_r;
      calc_done = done_sum;
    end
  end

  fpps_chunk #(
    .PAGE_BYTES   (PAGE_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_chunk (
    .page_i   (calc_page),
    .offset_i (calc_off),
    .length_i (calc_len),
    .done_i   (calc_done),
    .chunk_o  (chunk)
  );

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_start) begin
      if (phase_r == fpps_pkg::PH_IDLE) begin
        phase_nxt = fpps_pkg::PH_XFER;
      end
    end else begin
      case (phase_r)
        fpps_pkg::PH_XFER: begin
          if (s1_dma_r) begin
            phase_nxt = fpps_pkg::PH_PROG;
          end
        end
        fpps_pkg::PH_PROG: begin
          if (!busy) begin
            phase_nxt = all_done ? fpps_pkg::PH_IDLE : fpps_pkg::PH_XFER;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // result fields and sequence register updates
  always_comb begin
    action_nxt = fpps_pkg::ACT_NONE;
    addr_nxt   = '0;
    bytes_nxt  = '0;
    pos_nxt    = '0;
    page_nxt   = page_r;
    offset_nxt = offset_r;
    len_nxt    = len_r;
    done_nxt   = done_r;
    count_nxt  = count_r;
    if (is_start) begin
      if (phase_r == fpps_pkg::PH_IDLE) begin
        action_nxt = fpps_pkg::ACT_CHUNK;
        addr_nxt   = chunk.address;
        bytes_nxt  = chunk.bytes;
        pos_nxt    = '0;
        page_nxt   = calc_page;
        offset_nxt = calc_off;
        len_nxt    = s1_len_r;
        done_nxt   = '0;
        count_nxt  = chunk.bytes;
      end else begin
        action_nxt = fpps_pkg::ACT_REJECT;
      end
    end else begin
      case (phase_r)
        fpps_pkg::PH_XFER: begin
          if (s1_dma_r) begin
            action_nxt = fpps_pkg::ACT_END;
          end
        end
        fpps_pkg::PH_PROG: begin
          if (!busy) begin
            done_nxt = done_sum;
            if (all_done) begin
              action_nxt = fpps_pkg::ACT_DONE;
            end else begin
              action_nxt = fpps_pkg::ACT_CHUNK;
              addr_nxt   = chunk.address;
              bytes_nxt  = chunk.bytes;
              pos_nxt    = done_sum;
              page_nxt   = calc_page;
              offset_nxt = '0;
              count_nxt  = chunk.bytes;
            end
          end
        end
        default: action_nxt = fpps_pkg::ACT_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_page_r <= in_tdata[15:0];
      s1_off_r  <= in_tdata[23:16];
      s1_len_r  <= in_tdata[48:24];
      s1_dma_r  <= in_tdata[49];
      s1_stat_r <= in_tdata[57:50];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= fpps_pkg::PH_IDLE;
      page_r   <= '0;
      offset_r <= '0;
      len_r    <= '0;
      done_r   <= '0;
      count_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      page_r   <= page_nxt;
      offset_r <= offset_nxt;
      len_r    <= len_nxt;
      done_r   <= done_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_action_r <= action_nxt;
      out_addr_r   <= addr_nxt;
      out_bytes_r  <= bytes_nxt;
      out_pos_r    <= pos_nxt;
      out_idle_r   <= (phase_nxt == fpps_pkg::PH_IDLE);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_action_r;
  assign out_tdata  = {5'd0, out_idle_r, out_pos_r, out_bytes_r, out_addr_r};

endmodule

@@ src/fpps_chunk.sv @@
// Chunk calculator: flash address and byte count of the chunk at a page and offset.
// Depends on fpps_pkg.
module fpps_chunk #(
  parameter int PAGE_BYTES   = fpps_pkg::PAGE_BYTES_DEF,
  parameter int ADDRESS_BITS = fpps_pkg::ADDRESS_BITS_DEF
) (
  input  logic [fpps_pkg::PAGE_W-1:0]   page_i,
  input  logic [fpps_pkg::OFFSET_W-1:0] offset_i,
  input  logic [fpps_pkg::LEN_W-1:0]    length_i,
  input  logic [fpps_pkg::LEN_W-1:0]    done_i,
  output fpps_pkg::chunk_t              chunk_o
);

  localparam int PAGE_BITS = $clog2(PAGE_BYTES);
  localparam int FAW       = fpps_pkg::PAGE_W + PAGE_BITS;
  localparam logic [32:0] AMASK_W = (33'd1 << ADDRESS_BITS) - 33'd1;
  localparam logic [31:0] AMASK   = AMASK_W[31:0];
  localparam logic [fpps_pkg::LEN_W-1:0] PAGE_LEN = fpps_pkg::LEN_W'(PAGE_BYTES);

  logic [FAW-1:0]                full_addr;
  logic [31:0]                   addr32;
  logic [fpps_pkg::LEN_W-1:0]    room;
  logic [fpps_pkg::LEN_W-1:0]    left;
  logic [fpps_pkg::LEN_W-1:0]    count;

  assign full_addr = {page_i, {PAGE_BITS{1'b0}}} | FAW'(offset_i);
  assign addr32    = 32'(full_addr) & AMASK;
  assign room      = PAGE_LEN - fpps_pkg::LEN_W'(offset_i);
  assign left      = (length_i > done_i) ? (length_i - done_i) : '0;
  assign count     = (room < left) ? room : left;

  assign chunk_o.address = addr32[fpps_pkg::ADDR_W-1:0];
  assign chunk_o.bytes   = count[fpps_pkg::BYTES_W-1:0];

endmodule
